// ----- rtl/core/lzfd_pkg.sv -----
// Shared types and constants for the LZ77 flag-byte decompressor.
`default_nettype none

package lzfd_pkg;

  localparam int unsigned SIZE_BITS    = 24;
  localparam int unsigned COUNT_BITS   = SIZE_BITS + 1;
  localparam int unsigned WINDOW_DEPTH = 4096;
  localparam int unsigned WIN_AW       = $clog2(WINDOW_DEPTH);
  localparam int unsigned DIST_BITS    = WIN_AW + 1;
  localparam int unsigned LEN_BITS     = 5;
  localparam int unsigned FLAG_COUNT   = 8;

  localparam logic [LEN_BITS-1:0] MIN_MATCH = LEN_BITS'(3);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LIT,
    ST_COPY_PRE,
    ST_COPY,
    ST_PAD
  } state_e;

  typedef enum logic [1:0] {
    PH_FLAG,
    PH_TOKEN,
    PH_REF2
  } phase_e;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_padding;
    logic       last;
    logic       done_res;
    logic       bad_reference;
  } out_item_t;

endpackage

`default_nettype wire

// ----- rtl/core/lzfd_if.sv -----
// Handshake channel interfaces: compressed input, decoded output, size configuration.
`default_nettype none

interface lzfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       stream_start;

  modport source (output valid, output in_byte, output stream_start, input ready);
  modport sink   (input valid, input in_byte, input stream_start, output ready);
endinterface

interface lzfd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       is_padding;
  logic       last;
  logic       done_res;
  logic       bad_reference;

  modport source (output valid, output out_byte, output is_padding, output last,
                  output done_res, output bad_reference, input ready);
  modport sink   (input valid, input out_byte, input is_padding, input last,
                  input done_res, input bad_reference, output ready);
endinterface

interface lzfd_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [lzfd_pkg::SIZE_BITS-1:0] out_size;

  modport source (output valid, output out_size, input ready);
  modport sink   (input valid, input out_size, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/lzfd_window.sv -----
// History window: 4096 x 8 synchronous RAM, one write and one registered read port.
`default_nettype none

module lzfd_window (
  input  wire logic                        clk_i,
  input  wire logic                        we_i,
  input  wire logic [lzfd_pkg::WIN_AW-1:0] waddr_i,
  input  wire logic [7:0]                  wdata_i,
  input  wire logic [lzfd_pkg::WIN_AW-1:0] raddr_i,
  output logic      [7:0]                  rdata_o
);

  logic [7:0] mem [lzfd_pkg::WINDOW_DEPTH];

  // Read returns the old contents when the same entry is written in the same cycle.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

// ----- rtl/core/lzfd_out_reg.sv -----
// Output register stage between the decoder and the result channel.
`default_nettype none

module lzfd_out_reg (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                valid_i,
  output logic                     ready_o,
  input  wire lzfd_pkg::out_item_t item_i,
  lzfd_out_if.source               out_o
);

  logic                valid_q, valid_d;
  lzfd_pkg::out_item_t item_q, item_d;

  assign ready_o = !valid_q || out_o.ready;

  always_comb begin
    valid_d = valid_q;
    item_d  = item_q;
    if (ready_o) begin
      valid_d = valid_i;
      item_d  = item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign out_o.valid         = valid_q;
  assign out_o.out_byte      = item_q.out_byte;
  assign out_o.is_padding    = item_q.is_padding;
  assign out_o.last          = item_q.last;
  assign out_o.done_res      = item_q.done_res;
  assign out_o.bad_reference = item_q.bad_reference;

endmodule

`default_nettype wire

// ----- rtl/core/lz77_flag_byte_decompressor.sv -----
// Top level: LZ77 flag-byte decoder with history window and output register.
//
//  channel  | dir | payload                                            | accepted when
//  ---------+-----+----------------------------------------------------+-------------------
//  in_i     | in  | in_byte[7:0], stream_start                         | valid && ready
//  out_o    | out | out_byte[7:0], is_padding, last, done_res, bad_ref | valid && ready
//  cfg_i    | in  | out_size[23:0]                                     | valid && ready
//
// A flag byte or first match byte is only accepted; a literal is accepted, then emitted; a match
// is accepted, the window is prefetched for the single read port, then one byte per cycle is
// emitted while the output is not stalled. Padding adds up to 3 zero bytes.
// Reset clears the decoder state and out_size; the window is not cleared and only entries
// written by the current stream are ever used. A stalled output holds the byte generator.
`default_nettype none

module lz77_flag_byte_decompressor (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  lzfd_in_if.sink   in_i,
  lzfd_out_if.source out_o,
  lzfd_cfg_if.sink  cfg_i
);

  localparam int unsigned CW = lzfd_pkg::COUNT_BITS;
  localparam int unsigned AW = lzfd_pkg::WIN_AW;
  localparam int unsigned DW = lzfd_pkg::DIST_BITS;
  localparam int unsigned LW = lzfd_pkg::LEN_BITS;

  // Control state.
  lzfd_pkg::state_e              state_q, state_d;
  lzfd_pkg::phase_e              phase_q, phase_d;
  logic                          fin_q, fin_d;
  logic [CW-1:0]                 pc_q, pc_d;
  logic [7:0]                    flag_bits_q, flag_bits_d;
  logic [3:0]                    flags_left_q, flags_left_d;
  logic [7:0]                    first_ref_q, first_ref_d;
  logic [lzfd_pkg::SIZE_BITS-1:0] out_size_q, out_size_d;
  logic [1:0]                    pad_left_q, pad_left_d;
  logic [LW-1:0]                 cnt_q, cnt_d;

  // Per-token payload.
  logic [7:0]    lit_q, lit_d;
  logic [7:0]    hold_q, hold_d;
  logic [DW-1:0] dist_q, dist_d;
  logic [LW-1:0] len_q, len_d;
  logic          bad_q, bad_d;

  // Handshakes.
  logic in_acc;
  logic gen_valid, slot_rdy, emit;
  lzfd_pkg::out_item_t gen_item;

  // Effective state after an optional stream restart.
  lzfd_pkg::phase_e phase_e;
  logic          fin_e;
  logic [CW-1:0] pc_e;
  logic [7:0]    flag_bits_e;
  logic [3:0]    flags_left_e;
  logic [7:0]    first_ref_e;
  logic          reach_e;
  logic [1:0]    pad_e;

  // End-of-token bookkeeping.
  logic [CW-1:0] pc_inc;
  logic          reach_inc;
  logic [1:0]    pad_inc;
  logic          tok_end;
  logic [3:0]    flags_left_dec;

  // Window access.
  logic [7:0]    rdata;
  logic [CW-1:0] pc_rd;
  logic [AW-1:0] raddr;
  logic          src_ok, fwd;
  logic [7:0]    copy_v;
  logic [DW:0]   dist_new;

  assign in_i.ready  = (state_q == lzfd_pkg::ST_IDLE);
  assign in_acc      = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  // Restart clears the counters before the byte is taken.
  assign fin_e        = in_i.stream_start ? 1'b0 : fin_q;
  assign phase_e      = in_i.stream_start ? lzfd_pkg::PH_FLAG : phase_q;
  assign pc_e         = in_i.stream_start ? '0 : pc_q;
  assign flag_bits_e  = in_i.stream_start ? '0 : flag_bits_q;
  assign flags_left_e = in_i.stream_start ? '0 : flags_left_q;
  assign first_ref_e  = in_i.stream_start ? '0 : first_ref_q;
  assign reach_e      = pc_e >= CW'(out_size_q);
  assign pad_e        = 2'd0 - pc_e[1:0];

  assign pc_inc         = pc_q + CW'(1);
  assign reach_inc      = pc_inc >= CW'(out_size_q);
  assign pad_inc        = 2'd0 - pc_inc[1:0];
  assign flags_left_dec = flags_left_q - {3'd0, (flags_left_q != 4'd0)};
  assign tok_end        = (state_q == lzfd_pkg::ST_LIT) ||
                          ((state_q == lzfd_pkg::ST_COPY) && (cnt_q == len_q - LW'(1)));

  assign dist_new = {1'b0, first_ref_e[3:0], in_i.in_byte} + (DW + 1)'(1);

  // Copy source: zero before the stream start, forward the previous byte at distance one.
  assign src_ok = CW'(dist_q) <= pc_q;
  assign fwd    = (dist_q == DW'(1)) && (cnt_q != '0);
  assign copy_v = src_ok ? (fwd ? hold_q : rdata) : 8'd0;

  // Prefetch the source of the byte that will be emitted next.
  assign pc_rd = ((state_q == lzfd_pkg::ST_COPY) && emit) ? pc_inc : pc_q;
  assign raddr = pc_rd[AW-1:0] - dist_q[AW-1:0];

  // Result generation.
  always_comb begin
    gen_valid = state_q inside {lzfd_pkg::ST_LIT, lzfd_pkg::ST_COPY, lzfd_pkg::ST_PAD};
    gen_item  = '0;
    case (state_q)
      lzfd_pkg::ST_LIT: begin
        gen_item.out_byte = lit_q;
        gen_item.last     = !reach_inc || (pad_inc == 2'd0);
        gen_item.done_res = reach_inc && (pad_inc == 2'd0);
      end
      lzfd_pkg::ST_COPY: begin
        gen_item.out_byte      = copy_v;
        gen_item.bad_reference = bad_q;
        gen_item.last          = tok_end && (!reach_inc || (pad_inc == 2'd0));
        gen_item.done_res      = tok_end && reach_inc && (pad_inc == 2'd0);
      end
      lzfd_pkg::ST_PAD: begin
        gen_item.is_padding = 1'b1;
        gen_item.last       = (pad_left_q == 2'd1);
        gen_item.done_res   = (pad_left_q == 2'd1);
      end
      default: begin
        gen_item = '0;
      end
    endcase
  end

  assign emit = gen_valid && slot_rdy;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      lzfd_pkg::ST_IDLE: begin
        if (in_acc && !fin_e) begin
          case (phase_e)
            lzfd_pkg::PH_FLAG: begin
              if (reach_e && (pad_e != 2'd0)) state_d = lzfd_pkg::ST_PAD;
            end
            lzfd_pkg::PH_TOKEN: begin
              if (!flag_bits_e[7]) state_d = lzfd_pkg::ST_LIT;
            end
            lzfd_pkg::PH_REF2: begin
              state_d = lzfd_pkg::ST_COPY_PRE;
            end
            default: begin
              state_d = lzfd_pkg::ST_IDLE;
            end
          endcase
        end
      end
      lzfd_pkg::ST_LIT, lzfd_pkg::ST_COPY: begin
        if (emit && tok_end) begin
          state_d = (reach_inc && (pad_inc != 2'd0)) ? lzfd_pkg::ST_PAD : lzfd_pkg::ST_IDLE;
        end
      end
      lzfd_pkg::ST_COPY_PRE: begin
        state_d = lzfd_pkg::ST_COPY;
      end
      lzfd_pkg::ST_PAD: begin
        if (emit && (pad_left_q == 2'd1)) state_d = lzfd_pkg::ST_IDLE;
      end
      default: begin
        state_d = lzfd_pkg::ST_IDLE;
      end
    endcase
  end

  // Datapath and counters.
  always_comb begin
    phase_d      = phase_q;
    fin_d        = fin_q;
    pc_d         = pc_q;
    flag_bits_d  = flag_bits_q;
    flags_left_d = flags_left_q;
    first_ref_d  = first_ref_q;
    out_size_d   = out_size_q;
    pad_left_d   = pad_left_q;
    cnt_d        = cnt_q;
    lit_d        = lit_q;
    hold_d       = hold_q;
    dist_d       = dist_q;
    len_d        = len_q;
    bad_d        = bad_q;

    if (cfg_i.valid && cfg_i.ready) begin
      out_size_d = cfg_i.out_size;
    end

    if (in_acc) begin
      fin_d        = fin_e;
      phase_d      = phase_e;
      pc_d         = pc_e;
      flag_bits_d  = flag_bits_e;
      flags_left_d = flags_left_e;
      first_ref_d  = first_ref_e;
      if (!fin_e) begin
        case (phase_e)
          lzfd_pkg::PH_FLAG: begin
            if (reach_e) begin
              // Size already reached: drop the byte, pad and finish.
              fin_d      = 1'b1;
              pad_left_d = pad_e;
            end else begin
              flag_bits_d  = in_i.in_byte;
              flags_left_d = 4'(lzfd_pkg::FLAG_COUNT);
              phase_d      = lzfd_pkg::PH_TOKEN;
            end
          end
          lzfd_pkg::PH_TOKEN: begin
            if (flag_bits_e[7]) begin
              first_ref_d = in_i.in_byte;
              phase_d     = lzfd_pkg::PH_REF2;
            end else begin
              lit_d = in_i.in_byte;
            end
          end
          lzfd_pkg::PH_REF2: begin
            len_d  = LW'(first_ref_e[7:4]) + lzfd_pkg::MIN_MATCH;
            dist_d = dist_new[DW-1:0];
            bad_d  = CW'(dist_new[DW-1:0]) > pc_e;
            cnt_d  = '0;
          end
          default: begin
            phase_d = lzfd_pkg::PH_FLAG;
          end
        endcase
      end
    end

    if (emit) begin
      if (state_q == lzfd_pkg::ST_PAD) begin
        pad_left_d = pad_left_q - 2'd1;
      end else begin
        pc_d   = pc_inc;
        hold_d = gen_item.out_byte;
        cnt_d  = cnt_q + LW'(1);
        if (tok_end) begin
          flag_bits_d  = {flag_bits_q[6:0], 1'b0};
          flags_left_d = flags_left_dec;
          if (reach_inc) begin
            fin_d      = 1'b1;
            pad_left_d = pad_inc;
          end else begin
            phase_d = (flags_left_dec == 4'd0) ? lzfd_pkg::PH_FLAG : lzfd_pkg::PH_TOKEN;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= lzfd_pkg::ST_IDLE;
      phase_q      <= lzfd_pkg::PH_FLAG;
      fin_q        <= 1'b0;
      pc_q         <= '0;
      flag_bits_q  <= '0;
      flags_left_q <= '0;
      first_ref_q  <= '0;
      out_size_q   <= '0;
      pad_left_q   <= '0;
      cnt_q        <= '0;
    end else begin
      state_q      <= state_d;
      phase_q      <= phase_d;
      fin_q        <= fin_d;
      pc_q         <= pc_d;
      flag_bits_q  <= flag_bits_d;
      flags_left_q <= flags_left_d;
      first_ref_q  <= first_ref_d;
      out_size_q   <= out_size_d;
      pad_left_q   <= pad_left_d;
      cnt_q        <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lit_q  <= lit_d;
    hold_q <= hold_d;
    dist_q <= dist_d;
    len_q  <= len_d;
    bad_q  <= bad_d;
  end

  // Store every decoded byte, including zeros from references before the stream start.
  lzfd_window u_window (
    .clk_i   (clk_i),
    .we_i    (emit && (state_q != lzfd_pkg::ST_PAD)),
    .waddr_i (pc_q[AW-1:0]),
    .wdata_i (gen_item.out_byte),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  lzfd_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (gen_valid),
    .ready_o (slot_rdy),
    .item_i  (gen_item),
    .out_o   (out_o)
  );

  // Padding only happens once the stream has finished.
  a_pad_when_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lzfd_pkg::ST_PAD) |-> (fin_q && (pad_left_q != 2'd0)))
    else $error("padding state without finish or without bytes left");

  // The copy counter stays inside the match.
  a_copy_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lzfd_pkg::ST_COPY) |-> (cnt_q < len_q))
    else $error("copy counter past match length");

  // The final item of the stream leaves the decoder idle and finished.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && gen_item.done_res) |=> ((state_q == lzfd_pkg::ST_IDLE) && fin_q))
    else $error("decoder not finished after final item");

  // The window prefetch always precedes the first copied byte.
  a_prefetch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lzfd_pkg::ST_COPY_PRE) |=> ((state_q == lzfd_pkg::ST_COPY) && (cnt_q == '0)))
    else $error("copy did not start after prefetch");

endmodule

`default_nettype wire

// ----- verif/tb_lz77_flag_byte_decompressor.sv -----
// Testbench for the LZ77 flag-byte decompressor: predicts decoded items, checks each output.
`timescale 1ns / 1ps

module tb_lz77_flag_byte_decompressor;

  // Covers any match or padding work still in flight once the last expected
  // item has been seen.
  localparam int unsigned SETTLE_CYCLES   = 24;
  // Cycles without any handshake before the run is declared hung. The longest
  // legal quiet stretch is the receiver hold-off below.
  localparam int unsigned STALL_LIMIT     = 2000;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned RANDOM_ITEMS    = 250;
  localparam logic [lzfd_pkg::SIZE_BITS-1:0] SIZE_MAX = '1;

  logic clk_i = 1'b0;
  logic rst_ni;

  always #5 clk_i = ~clk_i;

  lzfd_in_if  in_ch ();
  lzfd_out_if out_ch ();
  lzfd_cfg_if cfg_ch ();

  lz77_flag_byte_decompressor u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  // Shared knobs between the test tasks and the receiver process.
  bit steady;      // no idling on either side while set
  bit hold_req;    // ask the receiver for one long hold-off
  bit in_offered;  // input valid is being driven high

  int unsigned failures;

  // Decoder model state: a private copy of everything the block keeps.
  logic [7:0]                      window [lzfd_pkg::WINDOW_DEPTH];
  logic [7:0]                      dec_flags;
  logic [3:0]                      dec_flags_left;
  lzfd_pkg::phase_e                dec_phase;
  logic [7:0]                      dec_ref_hi;
  logic [lzfd_pkg::COUNT_BITS-1:0] dec_count;
  bit                              dec_done;
  logic [lzfd_pkg::SIZE_BITS-1:0]  dec_out_size;

  lzfd_pkg::out_item_t step_bytes[$];      // items caused by the input item being decoded
  lzfd_pkg::out_item_t expected_bytes[$];  // decoded items still to come out of the block

  // ---------------------------------------------------------------------------
  // Decoder model
  // ---------------------------------------------------------------------------

  function automatic void emit(input logic [7:0] v, input logic pad, input logic bad);
    lzfd_pkg::out_item_t r;
    r.out_byte      = v;
    r.is_padding    = pad;
    r.last          = 1'b0;
    r.done_res      = 1'b0;
    r.bad_reference = bad;
    step_bytes.push_back(r);
  endfunction

  // Emit one decoded byte and append it to the history window.
  function automatic void put_decoded(input logic [7:0] v, input logic bad);
    emit(v, 1'b0, bad);
    window[dec_count[lzfd_pkg::WIN_AW-1:0]] = v;
    dec_count = dec_count + 1'b1;
  endfunction

  // Pad with zeros up to a multiple of 4; padding is not counted as output.
  function automatic void close_stream();
    logic [lzfd_pkg::COUNT_BITS-1:0] n;
    n = dec_count;
    while (n[1:0] != 2'b00) begin
      emit(8'h00, 1'b1, 1'b0);
      n = n + 1'b1;
    end
    dec_done = 1'b1;
  endfunction

  function automatic void token_done();
    dec_flags = dec_flags << 1;
    if (dec_flags_left > 0) dec_flags_left = dec_flags_left - 1'b1;
    if (dec_count >= dec_out_size) begin
      close_stream();
    end else begin
      dec_phase = (dec_flags_left == 0) ? lzfd_pkg::PH_FLAG : lzfd_pkg::PH_TOKEN;
    end
  endfunction

  function automatic void clear_stream();
    dec_flags      = '0;
    dec_flags_left = '0;
    dec_phase      = lzfd_pkg::PH_FLAG;
    dec_ref_hi     = '0;
    dec_count      = '0;
    dec_done       = 1'b0;
  endfunction

  // Work out the items that one accepted input item causes and queue them.
  function automatic void decode_step(input logic [7:0] b, input logic start);
    int unsigned                     len;
    int unsigned                     ref_dist;
    logic                            bad;
    logic [7:0]                      v;
    logic [lzfd_pkg::COUNT_BITS-1:0] src;
    step_bytes.delete();
    if (start) clear_stream();
    if (dec_done) return;
    case (dec_phase)
      lzfd_pkg::PH_FLAG: begin
        if (dec_count >= dec_out_size) begin
          close_stream();
        end else begin
          dec_flags      = b;
          dec_flags_left = 4'(lzfd_pkg::FLAG_COUNT);
          dec_phase      = lzfd_pkg::PH_TOKEN;
        end
      end
      lzfd_pkg::PH_TOKEN: begin
        if (dec_flags[7]) begin
          dec_ref_hi = b;
          dec_phase  = lzfd_pkg::PH_REF2;
        end else begin
          put_decoded(b, 1'b0);
          token_done();
        end
      end
      default: begin
        len      = dec_ref_hi[7:4] + lzfd_pkg::MIN_MATCH;
        ref_dist = {dec_ref_hi[3:0], b};
        ref_dist = ref_dist + 1;
        bad      = (ref_dist > dec_count);
        // The source check is redone per byte: a match that starts before the
        // stream can run into bytes it has just written itself.
        for (int unsigned j = 0; j < len; j++) begin
          if (ref_dist > dec_count) begin
            v = 8'h00;
          end else begin
            src = dec_count - lzfd_pkg::COUNT_BITS'(ref_dist);
            v   = window[src[lzfd_pkg::WIN_AW-1:0]];
          end
          put_decoded(v, bad);
        end
        token_done();
      end
    endcase
    if (step_bytes.size() > 0) begin
      step_bytes[$].last     = 1'b1;
      step_bytes[$].done_res = dec_done;
    end
    foreach (step_bytes[i]) expected_bytes.push_back(step_bytes[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Idling and driving
  // ---------------------------------------------------------------------------

  // Mostly short gaps, a few long ones.
  function automatic int unsigned idle_length();
    if ($urandom_range(0, 99) < 80) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int unsigned sender_gap();
    if (steady || $urandom_range(0, 99) < 70) return 0;
    return idle_length();
  endfunction

  // Drop valid, once, if it is being driven high.
  task automatic idle_input();
    if (in_offered) begin
      in_ch.valid <= 1'b0;
      in_offered  = 1'b0;
    end
  endtask

  // Offer one item and wait for it to be taken. Valid is left high on return:
  // the next call, or idle_input, sets it in the same step, so it is never
  // dropped and raised again within one step.
  task automatic send_byte(input logic [7:0] b, input logic start);
    int unsigned gap;
    gap = sender_gap();
    if (gap > 0) begin
      idle_input();
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid        <= 1'b1;
    in_ch.in_byte      <= b;
    in_ch.stream_start <= start;
    in_offered         = 1'b1;
    do @(posedge clk_i); while (!in_ch.ready);
    decode_step(b, start);
  endtask

  // Hold the input until every expected item has come out.
  task automatic wait_drained();
    idle_input();
    while (expected_bytes.size() != 0) @(posedge clk_i);
  endtask

  // Write the size register only once the block has gone idle.
  task automatic write_out_size(input logic [lzfd_pkg::SIZE_BITS-1:0] size);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_ch.valid    <= 1'b1;
    cfg_ch.out_size <= size;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    dec_out_size = size;
  endtask

  // Feed one well-formed stream with random content. Match distances mostly
  // stay inside what the stream has produced; a few reach before its start.
  // Stops when the stream finishes or max_items have gone, in which case the
  // next stream start cuts it off.
  task automatic run_stream(input int unsigned max_items, input bit favor_long,
                            output int unsigned sent);
    logic [7:0]  b;
    logic [7:0]  dist_lo;
    logic [11:0] dist_m1;
    logic [3:0]  len_nib;
    int unsigned span;
    dist_lo = 8'h00;
    sent    = 0;
    while (sent < max_items && (sent == 0 || !dec_done)) begin
      if (sent > 0 && $urandom_range(0, 99) < 3) wait_drained();
      b = 8'($urandom);
      if (sent > 0 && dec_phase == lzfd_pkg::PH_TOKEN && dec_flags[7]) begin
        span = (dec_count > lzfd_pkg::WINDOW_DEPTH) ? lzfd_pkg::WINDOW_DEPTH
                                                    : int'(dec_count);
        if (span == 0 || $urandom_range(0, 99) < 8) begin
          dist_m1 = 12'($urandom);
        end else if ($urandom_range(0, 99) < 20) begin
          dist_m1 = 12'(span - 1);
        end else begin
          dist_m1 = 12'($urandom_range(1, span) - 1);
        end
        len_nib = (favor_long && $urandom_range(0, 99) < 70) ? 4'hf : 4'($urandom);
        b       = {len_nib, dist_m1[11:8]};
        dist_lo = dist_m1[7:0];
      end else if (sent > 0 && dec_phase == lzfd_pkg::PH_REF2 &&
                   $urandom_range(0, 99) >= 3) begin
        b = dist_lo;
      end
      send_byte(b, sent == 0);
      sent++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver and checker
  // ---------------------------------------------------------------------------

  initial begin
    int unsigned stall;
    stall = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall > 0) begin
        stall--;
        out_ch.ready <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        stall    = HOLD_OFF_CYCLES - 1;
        out_ch.ready <= 1'b0;
      end else if (!steady && $urandom_range(0, 99) < 15) begin
        stall = idle_length() - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      failures++;
    end
  endfunction

  always @(posedge clk_i) begin
    lzfd_pkg::out_item_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (expected_bytes.size() == 0) begin
        $error("unexpected item: out_byte %0h is_padding %0b", out_ch.out_byte,
               out_ch.is_padding);
        failures++;
      end else begin
        want = expected_bytes.pop_front();
        check_field("out_byte", want.out_byte, out_ch.out_byte);
        check_field("is_padding", want.is_padding, out_ch.is_padding);
        check_field("last", want.last, out_ch.last);
        check_field("done_res", want.done_res, out_ch.done_res);
        check_field("bad_reference", want.bad_reference, out_ch.bad_reference);
      end
    end
  end

  // Hang detection: end the run if no channel moves an item for too long.
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("*** FAILED ***");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Literal, then an 18-byte match at distance 1 that overlaps itself. The size
  // is hit inside the flag byte: drop the remaining flags, pad, and ignore the
  // byte that follows the finished stream.
  task automatic test_literal_and_long_match();
    write_out_size(24'd10);
    send_byte(8'h40, 1'b1);
    send_byte(8'hff, 1'b0);
    send_byte(8'hf0, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h55, 1'b0);
  endtask

  // Matches around the stream start: the farthest distance on an empty
  // stream, a match that reads back zeros the first one wrote, and one that is
  // short of history by a single byte. Run without idling.
  task automatic test_bad_reference();
    steady = 1'b1;
    write_out_size(SIZE_MAX);
    send_byte(8'hff, 1'b1);
    send_byte(8'h0f, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h02, 1'b0);
    send_byte(8'h10, 1'b0);
    send_byte(8'h06, 1'b0);
    wait_drained();
    steady = 1'b0;
  endtask

  // Size zero finishes on the flag byte with nothing to emit; then a size
  // lowered below the count mid-stream finishes on the next flag byte with
  // padding only.
  task automatic test_size_limits();
    write_out_size('0);
    send_byte(8'h00, 1'b1);
    send_byte(8'h12, 1'b0);
    write_out_size(24'd100);
    send_byte(8'h01, 1'b1);
    for (int i = 1; i <= 7; i++) send_byte(8'(i * 8'h11), 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h06, 1'b0);
    write_out_size(24'd4);
    send_byte(8'hab, 1'b0);
  endtask

  // Hold the receiver off for a long stretch while long matches keep coming,
  // so the block backs up into its input; then pause until it has drained.
  task automatic test_output_holdoff();
    int unsigned sent;
    write_out_size(24'd200);
    hold_req = 1'b1;
    run_stream(30, 1'b1, sent);
    wait_drained();
  endtask

  // Random streams under random sizes, some cut off by a new stream start,
  // some followed by bytes that a finished stream must ignore.
  task automatic test_random_streams();
    int unsigned                    total;
    int unsigned                    sent;
    int unsigned                    pick;
    logic [lzfd_pkg::SIZE_BITS-1:0] size;
    total = 0;
    while (total < RANDOM_ITEMS) begin
      if (total == 0 || $urandom_range(0, 99) < 60) begin
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
          size = '0;
        end else if (pick < 16) begin
          size = SIZE_MAX;
        end else if (pick < 30) begin
          size = lzfd_pkg::SIZE_BITS'($urandom_range(1, 4));
        end else begin
          size = lzfd_pkg::SIZE_BITS'($urandom_range(5, 120));
        end
        write_out_size(size);
      end
      steady = ($urandom_range(0, 99) < 15);
      run_stream($urandom_range(2, 40), 1'b0, sent);
      total += sent;
      if (dec_done && $urandom_range(0, 1) == 1) begin
        repeat ($urandom_range(1, 2)) send_byte(8'($urandom), 1'b0);
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    rst_ni             <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.in_byte      <= 8'h00;
    in_ch.stream_start <= 1'b0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.out_size    <= '0;
    failures     = 0;
    steady       = 1'b0;
    hold_req     = 1'b0;
    in_offered   = 1'b0;
    dec_out_size = '0;
    clear_stream();
    foreach (window[i]) window[i] = 8'h00;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_literal_and_long_match();
    test_bad_reference();
    test_size_limits();
    test_output_holdoff();
    test_random_streams();

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (failures == 0 && expected_bytes.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
